[rtl/base64_stream_encoder_top_macros.svh]
// assertion macros for the base64 stream encoder
// used by base64_stream_encoder_top; no other dependencies
`ifndef BASE64_STREAM_ENCODER_TOP_MACROS_SVH
`define BASE64_STREAM_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define B64SE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define B64SE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define B64SE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define B64SE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/b64se_pkg.sv]
// shared types, constants and the alphabet lookup for the base64 stream encoder
// no dependencies
`timescale 1ns / 1ps

package b64se_pkg;

	localparam int SEXT_W = 6;
	localparam int CHAR_W = 7;

	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_PLUS    = 7'h2B;
	localparam logic [CHAR_W-1:0] CHAR_SLASH   = 7'h2F;
	localparam logic [CHAR_W-1:0] CHAR_PAD     = 7'h3D;

	// one encoded group waiting to be serialized
	typedef struct packed {
		logic [3:0][SEXT_W-1:0] sext;
		logic [2:0]             data_chars;
		logic                   msg_end;
	} group_t;

	function automatic logic [CHAR_W-1:0] b64_char(input logic [SEXT_W-1:0] v);
		logic [CHAR_W-1:0] ve;
		logic [CHAR_W-1:0] r;
		ve = {1'b0, v};
		if (v < 6'd26)
			r = CHAR_UPPER_A + ve;
		else if (v < 6'd52)
			r = CHAR_LOWER_A + ve - 7'd26;
		else if (v < 6'd62)
			r = CHAR_DIGIT_0 + ve - 7'd52;
		else if (v == 6'd62)
			r = CHAR_PLUS;
		else
			r = CHAR_SLASH;
		return r;
	endfunction

endpackage

[rtl/base64_stream_encoder_top.sv]
// the byte that closes a group is written to the group queue, then its first character
// goes to the output register; throughput: one byte per cycle in while the group queue
// has room, one character per cycle out while the receiver pops; every group leaves as
// four characters, and the group queue (QUEUE_DEPTH entries) lets bytes keep coming while
// characters drain; full holds every byte once it fills
// reset: asynchronous, clears pending byte count, queue pointers and fill count, character index and output valid
`timescale 1ns / 1ps
`include "base64_stream_encoder_top_macros.svh"

module base64_stream_encoder_top import b64se_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        data_byte,
	input  logic              message_end,
	output logic              empty,
	input  logic              pop,
	output logic [CHAR_W-1:0] out_char,
	output logic              run_last,
	output logic              stream_last
);

	logic   accept;
	logic   grp_push;
	group_t grp;
	group_t head;
	logic   head_empty;
	logic   head_pop;

	assign accept = push && !full;

	b64se_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.message_end(message_end),
		.grp_push   (grp_push),
		.grp        (grp)
	);

	b64se_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (grp_push),
		.wr_data(grp),
		.full   (full),
		.rd_en  (head_pop),
		.rd_data(head),
		.empty  (head_empty)
	);

	b64se_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.out_char   (out_char),
		.run_last   (run_last),
		.stream_last(stream_last)
	);

	// a waiting group always keeps a character on the output
	`B64SE_ASSERT_NEXT(a_head_drains, clk, arst_n, !head_empty, !empty, "group waiting but output empty")
	// the message end only lands on the last character of a group
	`B64SE_ASSERT_IMPLIES(a_stream_last_run, clk, arst_n, !empty && stream_last, run_last, "stream_last without run_last")
	// every group at the queue head carries two, three or four data characters
	`B64SE_ASSERT_IMPLIES(a_head_chars, clk, arst_n, !head_empty, head.data_chars == 3'd2 || head.data_chars == 3'd3 || head.data_chars == 3'd4, "bad data character count")

endmodule

[rtl/b64se_front.sv]
// front end: takes bytes, holds a partial group, builds sextets of a finished group
// depends on b64se_pkg
`timescale 1ns / 1ps

module b64se_front import b64se_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       message_end,
	output logic       grp_push,
	output group_t     grp
);

	logic [1:0][7:0] held_q;
	logic [1:0]      count_q;
	logic [1:0]      have;
	logic            complete;
	logic [7:0]      g0, g1, g2;

	// a count of three cannot happen; treat it as two
	assign have     = (count_q == 2'd3) ? 2'd2 : count_q;
	assign complete = (have == 2'd2) || message_end;
	assign grp_push = accept && complete;

	always_comb begin
		g0 = (have != 2'd0) ? held_q[0] : data_byte;
		if (have == 2'd2)
			g1 = held_q[1];
		else if (have == 2'd1)
			g1 = data_byte;
		else
			g1 = 8'h00;
		g2 = (have == 2'd2) ? data_byte : 8'h00;

		grp.sext[0]    = g0[7:2];
		grp.sext[1]    = {g0[1:0], g1[7:4]};
		grp.sext[2]    = {g1[3:0], g2[7:6]};
		grp.sext[3]    = g2[5:0];
		grp.data_chars = (have == 2'd2) ? 3'd4 : ({1'b0, have} + 3'd2);
		grp.msg_end    = message_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (accept) begin
			count_q <= complete ? 2'd0 : (have + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !complete)
			held_q[have[0]] <= data_byte;
	end

endmodule

[rtl/b64se_queue.sv]
// small queue of encoded groups between front and back end
// depends on b64se_pkg
`timescale 1ns / 1ps

module b64se_queue import b64se_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  group_t wr_data,
	output logic   full,
	input  logic   rd_en,
	output group_t rd_data,
	output logic   empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	group_t             entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			entries_q[wr_ptr_q] <= wr_data;
	end

endmodule

[rtl/b64se_back.sv]
// back end: serializes the queue head into four characters, one per cycle while the output is empty or popped
// depends on b64se_pkg
`timescale 1ns / 1ps

module b64se_back import b64se_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  group_t            head,
	input  logic              head_empty,
	output logic              head_pop,
	input  logic              pop,
	output logic              empty,
	output logic [CHAR_W-1:0] out_char,
	output logic              run_last,
	output logic              stream_last
);

	logic              valid_q;
	logic [1:0]        idx_q;
	logic [CHAR_W-1:0] char_q;
	logic              run_last_q;
	logic              stream_last_q;
	logic              slot_free;
	logic              take;

	// output register can be refilled in the cycle its transaction completes
	assign slot_free = !valid_q || pop;
	assign take      = slot_free && !head_empty;
	assign head_pop  = take && (idx_q == 2'd3);

	assign empty       = !valid_q;
	assign out_char    = char_q;
	assign run_last    = run_last_q;
	assign stream_last = stream_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (slot_free) begin
			valid_q <= !head_empty;
			if (take)
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_q        <= ({1'b0, idx_q} < head.data_chars) ? b64_char(head.sext[idx_q])
			                                                   : CHAR_PAD;
			run_last_q    <= (idx_q == 2'd3);
			stream_last_q <= (idx_q == 2'd3) && head.msg_end;
		end
	end

endmodule

[tb/b64_encode_checker.sv]
// watches the byte and character channels of the base64 stream encoder,
// predicts every encoded character and compares; depends on b64se_pkg
`timescale 1ns / 1ps

module b64_encode_checker import b64se_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [7:0]        data_byte,
	input  logic              message_end,
	input  logic              empty,
	input  logic              pop,
	input  logic [CHAR_W-1:0] out_char,
	input  logic              run_last,
	input  logic              stream_last,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              run_last;
		logic              stream_last;
	} enc_char_t;

	string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	enc_char_t   exp_chars[$];
	logic [7:0]  held_bytes[2];
	logic [1:0]  held_count;

	initial begin
		errors = 0;
		pending = 0;
		held_count = 2'd0;
	end

	// one accepted byte: either held, or closes a group into four characters
	task automatic encode_byte(input logic [7:0] b, input logic last_mark);
		logic [7:0]        g0, g1, g2;
		logic [5:0]        sext[4];
		int                n_data;
		enc_char_t         c;
		byte               ab;
		if (held_count < 2'd2 && !last_mark) begin
			held_bytes[held_count[0]] = b;
			held_count = held_count + 2'd1;
			return;
		end
		g0 = (held_count >= 2'd1) ? held_bytes[0] : b;
		g1 = (held_count == 2'd2) ? held_bytes[1] : ((held_count == 2'd1) ? b : 8'h00);
		g2 = (held_count == 2'd2) ? b : 8'h00;
		sext[0] = g0[7:2];
		sext[1] = {g0[1:0], g1[7:4]};
		sext[2] = {g1[3:0], g2[7:6]};
		sext[3] = g2[5:0];
		n_data = (held_count == 2'd2) ? 4 : int'(held_count) + 2;
		for (int k = 0; k < 4; k++) begin
			ab = alphabet[sext[k]];
			c.ch = (k < n_data) ? ab[CHAR_W-1:0] : CHAR_PAD;
			c.run_last = (k == 3);
			c.stream_last = (k == 3) && last_mark;
			exp_chars.push_back(c);
		end
		held_count = 2'd0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		enc_char_t e;
		if (!arst_n) begin
			exp_chars.delete();
			held_count = 2'd0;
		end else begin
			if (pop && !empty) begin
				if (exp_chars.size() == 0) begin
					$error("unexpected character transaction: out_char %h", out_char);
					errors++;
				end else begin
					e = exp_chars.pop_front();
					if (out_char !== e.ch) begin
						$error("out_char: expected %h, actual %h", e.ch, out_char);
						errors++;
					end
					if (run_last !== e.run_last) begin
						$error("run_last: expected %b, actual %b", e.run_last, run_last);
						errors++;
					end
					if (stream_last !== e.stream_last) begin
						$error("stream_last: expected %b, actual %b", e.stream_last,
							stream_last);
						errors++;
					end
				end
			end
			if (push && !full)
				encode_byte(data_byte, message_end);
		end
		pending = exp_chars.size();
	end

endmodule

[tb/tb_base64_stream_encoder_top.sv]
// stimulus and verdict for base64_stream_encoder_top; bytes go in bursts,
// characters are popped on a shifting stall pattern; uses b64_encode_checker
`timescale 1ns / 1ps

module tb_base64_stream_encoder_top import b64se_pkg::*;;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [7:0]        data_byte = 8'h00;
	logic              message_end = 1'b0;
	logic              empty;
	logic              pop = 1'b0;
	logic [CHAR_W-1:0] out_char;
	logic              run_last;
	logic              stream_last;
	int                errors;
	int                pending;
	int                burst_left;
	int                bytes_sent;
	int                rx_cycle;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	base64_stream_encoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.message_end(message_end),
		.empty(empty),
		.pop(pop),
		.out_char(out_char),
		.run_last(run_last),
		.stream_last(stream_last)
	);

	b64_encode_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.message_end(message_end),
		.empty(empty),
		.pop(pop),
		.out_char(out_char),
		.run_last(run_last),
		.stream_last(stream_last),
		.errors(errors),
		.pending(pending)
	);

	// receiver: the stall pattern rotates between always popping, random, periodic and rare pops
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			rx_cycle <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			case ((rx_cycle / 64) % 4)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 1) == 1);
				2: pop <= (rx_cycle % 4 == 0);
				default: pop <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// one byte transaction, then a random gap when the burst runs out
	task automatic send_byte(input logic [7:0] b, input logic last_mark);
		push <= 1'b1;
		data_byte <= b;
		message_end <= last_mark;
		do
			@(posedge clk);
		while (full);
		bytes_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
		end
	endtask

	task automatic send_message(input logic [7:0] msg[$]);
		for (int i = 0; i < msg.size(); i++)
			send_byte(msg[i], i == msg.size() - 1);
	endtask

	initial begin
		logic [7:0] msg[$];
		int         len;
		bytes_sent = 0;
		burst_left = 5;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one byte, two bytes, full groups, the '+' and '/' codes, zeros
		send_message('{8'h00});
		send_message('{8'hFF});
		send_message('{8'hFF, 8'hFF});
		send_message('{8'h00, 8'h00});
		send_message('{8'hFB, 8'hEF, 8'hBE});
		send_message('{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00});
		send_message('{8'h4D, 8'h61, 8'h6E, 8'h31});
		send_message('{8'h80, 8'h01, 8'h7F, 8'hFE});

		while (bytes_sent < 106) begin
			msg.delete();
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 7))
					0: msg.push_back(8'h00);
					1: msg.push_back(8'hFF);
					default: msg.push_back(8'($urandom));
				endcase
			end
			send_message(msg);
		end
		push <= 1'b0;

		// let the checker count the last transaction before waiting on it
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#400000;
		$display("Verification failed");
		$finish;
	end

endmodule
